FILE: hdl/gfr_pkg.sv
// ----------------------------------------------------------------------------
// gfr_pkg
// Types and constants shared by the gamepad frame receiver modules.
// ----------------------------------------------------------------------------
package gfr_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned HUNT_W       = 5;
    localparam int unsigned FAIL_W       = 3;
    localparam int unsigned CFG_ADDR_W   = 2;
    localparam int unsigned CFG_DATA_W   = 8;
    localparam int unsigned OUT_TDATA_W  = 56;

    localparam logic [CFG_ADDR_W-1:0] CFG_HEADER  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TRAILER = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HUNT    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FAIL    = 2'd3;

    localparam logic [BYTE_W-1:0] HEADER_RST  = 8'hEB;
    localparam logic [BYTE_W-1:0] TRAILER_RST = 8'hAF;
    localparam logic [HUNT_W-1:0] HUNT_RST    = 5'd15;
    localparam logic [FAIL_W-1:0] FAIL_RST    = 3'd2;
    localparam logic [FAIL_W-1:0] FAIL_SAT    = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] header_byte;
        logic [BYTE_W-1:0] trailer_byte;
        logic [HUNT_W-1:0] hunt_limit;
        logic [FAIL_W-1:0] fail_limit;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] left_x;
        logic [BYTE_W-1:0] left_y;
        logic [BYTE_W-1:0] right_x;
        logic [BYTE_W-1:0] right_y;
        logic [15:0]       buttons;
        logic              checksum_ok;
        logic              trailer_ok;
        logic              hunt_timeout;
        logic              link_lost;
    } t_result;

endpackage

FILE: hdl/gfr_cfg.sv
// ----------------------------------------------------------------------------
// gfr_cfg
// Configuration register bank written through a plain write port.
// ----------------------------------------------------------------------------
module gfr_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [gfr_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [gfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output gfr_pkg::t_cfg                  o_cfg
);
    import gfr_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_byte  <= HEADER_RST;
            r_cfg.trailer_byte <= TRAILER_RST;
            r_cfg.hunt_limit   <= HUNT_RST;
            r_cfg.fail_limit   <= FAIL_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_HEADER:  r_cfg.header_byte  <= i_cfg_data[BYTE_W-1:0];
                CFG_TRAILER: r_cfg.trailer_byte <= i_cfg_data[BYTE_W-1:0];
                CFG_HUNT:    r_cfg.hunt_limit   <= i_cfg_data[HUNT_W-1:0];
                CFG_FAIL:    r_cfg.fail_limit   <= i_cfg_data[FAIL_W-1:0];
                default:     r_cfg              <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/gfr_parser.sv
// ----------------------------------------------------------------------------
// gfr_parser
// Per-byte frame parser: header hunt, field capture, checksum and failure
// tracking. Updates its state on each accepted byte and presents a result.
// ----------------------------------------------------------------------------
module gfr_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [gfr_pkg::BYTE_W-1:0] i_rx_byte,
    input  gfr_pkg::t_cfg              i_cfg,
    output logic                       o_res_valid,
    output gfr_pkg::t_result           o_res
);
    import gfr_pkg::*;

    localparam logic [3:0] PH_HUNT  = 4'd0;
    localparam logic [3:0] PH_LX    = 4'd1;
    localparam logic [3:0] PH_LY    = 4'd2;
    localparam logic [3:0] PH_RX    = 4'd3;
    localparam logic [3:0] PH_RY    = 4'd4;
    localparam logic [3:0] PH_BTN1  = 4'd5;
    localparam logic [3:0] PH_BTN2  = 4'd6;
    localparam logic [3:0] PH_SUM   = 4'd7;
    localparam logic [3:0] PH_TRAIL = 4'd8;

    logic [3:0]        r_phase,    n_phase;
    logic [HUNT_W-1:0] r_hunt_cnt, n_hunt_cnt;
    logic [BYTE_W-1:0] r_sum,      n_sum;
    logic [FAIL_W-1:0] r_fail_cnt, n_fail_cnt;
    logic [BYTE_W-1:0] r_rx_sum;
    logic [BYTE_W-1:0] r_field [6];

    logic              store_en;
    logic [2:0]        store_idx;
    logic              sum_ok;
    logic              end_ok;
    logic              res_valid;
    logic              res_fail;
    logic              res_good;
    t_result           res;

    assign sum_ok    = (r_rx_sum == r_sum);
    assign end_ok    = (i_rx_byte == i_cfg.trailer_byte);
    assign store_idx = r_phase[2:0] - 3'd1;

    always_comb begin
        n_phase    = r_phase;
        n_hunt_cnt = r_hunt_cnt;
        n_sum      = r_sum;
        store_en   = 1'b0;
        res_valid  = 1'b0;
        res_fail   = 1'b0;
        res_good   = 1'b0;
        res        = '0;
        unique case (r_phase) inside
            PH_LX, PH_LY, PH_RX, PH_RY, PH_BTN1, PH_BTN2: begin
                store_en = 1'b1;
                n_sum    = r_sum + i_rx_byte;
                n_phase  = r_phase + 4'd1;
            end
            PH_SUM: begin
                n_phase = PH_TRAIL;
            end
            PH_TRAIL: begin
                res_valid       = 1'b1;
                res_good        = sum_ok && end_ok;
                res_fail        = !(sum_ok && end_ok);
                res.left_x      = r_field[0];
                res.left_y      = r_field[1];
                res.right_x     = r_field[2];
                res.right_y     = r_field[3];
                res.buttons     = {r_field[5], r_field[4]};
                res.checksum_ok = sum_ok;
                res.trailer_ok  = end_ok;
                n_phase         = PH_HUNT;
                n_hunt_cnt      = '0;
            end
            default: begin
                if (i_rx_byte == i_cfg.header_byte) begin
                    n_hunt_cnt = '0;
                    n_sum      = '0;
                    n_phase    = PH_LX;
                end else begin
                    n_phase = PH_HUNT;
                    if (r_hunt_cnt >= i_cfg.hunt_limit) begin
                        n_hunt_cnt       = '0;
                        res_valid        = 1'b1;
                        res_fail         = 1'b1;
                        res.hunt_timeout = 1'b1;
                    end else begin
                        n_hunt_cnt = r_hunt_cnt + 5'd1;
                    end
                end
            end
        endcase

        n_fail_cnt = r_fail_cnt;
        if (res_good) begin
            n_fail_cnt = '0;
        end else if (res_fail && (r_fail_cnt != FAIL_SAT)) begin
            n_fail_cnt = r_fail_cnt + 3'd1;
        end
        res.link_lost = (n_fail_cnt > i_cfg.fail_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_hunt_cnt <= '0;
            r_sum      <= '0;
            r_fail_cnt <= '0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_hunt_cnt <= n_hunt_cnt;
            r_sum      <= n_sum;
            r_fail_cnt <= n_fail_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && store_en) begin
            r_field[store_idx] <= i_rx_byte;
        end
        if (i_accept && (r_phase == PH_SUM)) begin
            r_rx_sum <= i_rx_byte;
        end
    end

    assign o_res_valid = i_accept && res_valid;
    assign o_res       = res;

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_TRAIL)
        else $error("frame phase out of range");

    a_timeout_clears_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.hunt_timeout) |=> (r_hunt_cnt == '0))
        else $error("hunt count not cleared after timeout");

    a_good_clears_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.hunt_timeout && o_res.checksum_ok && o_res.trailer_ok)
        |=> (r_fail_cnt == '0))
        else $error("failure count not cleared by a good frame");

    a_timeout_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.hunt_timeout) |-> (!o_res.checksum_ok && !o_res.trailer_ok))
        else $error("timeout result carries frame flags");

    a_frame_ends_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.hunt_timeout) |=> (r_phase == PH_HUNT))
        else $error("parser not hunting after a frame result");

endmodule

FILE: hdl/gfr_outbuf.sv
// ----------------------------------------------------------------------------
// gfr_outbuf
// Output register with a skid stage, so that a new byte can be taken while
// a finished result waits for the downstream side.
// ----------------------------------------------------------------------------
module gfr_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_res_valid,
    input  gfr_pkg::t_result i_res,
    output logic             o_in_ready,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output gfr_pkg::t_result o_res
);
    import gfr_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_res_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_res_valid;
            end
        end else if (i_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_res_ready) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_res_valid) begin
            r_skid <= i_res;
        end
    end

    assign o_in_ready  = !r_skid_valid;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a word while the output is empty");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_res_valid)
        else $error("result arrived while the skid stage was full");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_res_ready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid stage did not drain into the output register");

endmodule

FILE: hdl/gamepad_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// gamepad_frame_receiver_top
// Byte-stream parser for gamepad frames: header hunt with timeout, stick and
// button capture, checksum and trailer check, and a link-lost indication.
//
// Channel   Dir  Word                         Meaning
// s_axis    in   tdata[7:0] rx_byte           one received serial byte
// m_axis    out  tdata[55:0], tuser[0]        one frame or timeout result
// cfg       in   i_cfg_wr_en/addr/data        register write, no read-back
//
// One byte is accepted per cycle while s_axis_tready is high; its result, if
// any, is registered in the single output register stage or the skid stage.
// Reset is synchronous and active low; the cfg registers return to defaults.
// A stalled m_axis is absorbed by a one-word skid stage; s_axis_tready drops
// only while both the output register and the skid stage are full.
// ----------------------------------------------------------------------------
module gamepad_frame_receiver_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [7:0] rx_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] left_x, [15:8] left_y, [23:16] right_x, [31:24] right_y,
    // [47:32] buttons, [48] checksum_ok, [49] trailer_ok, [50] link_lost
    output logic [gfr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tuser,  // [0] hunt_timeout
    input  logic                                i_cfg_wr_en,
    input  logic [gfr_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [gfr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import gfr_pkg::*;

    t_cfg    cfg;
    t_result parse_res;
    t_result out_res;
    logic    parse_valid;
    logic    in_ready;
    logic    accept;

    assign accept = s_axis_tvalid && in_ready;

    gfr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    gfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (s_axis_tdata),
        .i_cfg       (cfg),
        .o_res_valid (parse_valid),
        .o_res       (parse_res)
    );

    gfr_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (parse_valid),
        .i_res       (parse_res),
        .o_in_ready  (in_ready),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (out_res)
    );

    assign s_axis_tready = in_ready;
    assign m_axis_tuser  = out_res.hunt_timeout;
    assign m_axis_tdata  = {5'd0,
                            out_res.link_lost,
                            out_res.trailer_ok,
                            out_res.checksum_ok,
                            out_res.buttons,
                            out_res.right_y,
                            out_res.right_x,
                            out_res.left_y,
                            out_res.left_x};

endmodule

FILE: sim/tb_gamepad_frame_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gamepad_frame_receiver_top
// Drives received bytes into the frame receiver and checks every result word
// against a predictor of the header hunt, frame capture, checksum, trailer
// and link-lost logic. A short directed sequence is followed by random
// frames, broken frames and noise under several register settings, with
// random gaps on both streams.
// ----------------------------------------------------------------------------
module tb_gamepad_frame_receiver_top;

    import gfr_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASE_BYTES   = 160;
    localparam int NUM_SETTINGS  = 8;

    class frame_scoreboard;
        localparam logic [3:0] PH_HUNT    = 4'd0;
        localparam logic [3:0] PH_FIRST   = 4'd1;
        localparam logic [3:0] PH_SUM     = 4'd7;
        localparam logic [3:0] PH_TRAILER = 4'd8;

        t_cfg              regs;
        logic [3:0]        phase;
        logic [HUNT_W-1:0] hunt_count;
        logic [BYTE_W-1:0] fields [6];
        logic [BYTE_W-1:0] sum_acc;
        logic [BYTE_W-1:0] sum_rx;
        logic [FAIL_W-1:0] fails;
        t_result           results_due [$];
        int                errors;
        int                bytes_in;
        int                frames;
        int                good_frames;
        int                timeouts;
        int                lost_results;

        function new();
            regs.header_byte  = HEADER_RST;
            regs.trailer_byte = TRAILER_RST;
            regs.hunt_limit   = HUNT_RST;
            regs.fail_limit   = FAIL_RST;
            phase      = PH_HUNT;
            hunt_count = '0;
            sum_acc    = '0;
            sum_rx     = '0;
            fails      = '0;
            foreach (fields[i]) fields[i] = '0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_HEADER:  regs.header_byte  = v[BYTE_W-1:0];
                CFG_TRAILER: regs.trailer_byte = v[BYTE_W-1:0];
                CFG_HUNT:    regs.hunt_limit   = v[HUNT_W-1:0];
                CFG_FAIL:    regs.fail_limit   = v[FAIL_W-1:0];
                default: ;
            endcase
        endfunction

        function void tally_outcome(bit good);
            if (good) begin
                fails = '0;
            end else if (fails != FAIL_SAT) begin
                fails = fails + 3'd1;
            end
        endfunction

        function void queue_result(t_result r);
            r.link_lost = (fails > regs.fail_limit);
            if (r.link_lost) lost_results++;
            results_due.push_back(r);
        endfunction

        function void accept_byte(logic [BYTE_W-1:0] b);
            t_result r;
            r = '0;
            bytes_in++;
            if (phase >= PH_FIRST && phase < PH_SUM) begin
                fields[int'(phase) - 1] = b;
                sum_acc = sum_acc + b;
                phase = phase + 4'd1;
            end else if (phase == PH_SUM) begin
                sum_rx = b;
                phase = PH_TRAILER;
            end else if (phase == PH_TRAILER) begin
                r.left_x      = fields[0];
                r.left_y      = fields[1];
                r.right_x     = fields[2];
                r.right_y     = fields[3];
                r.buttons     = {fields[5], fields[4]};
                r.checksum_ok = (sum_rx == sum_acc);
                r.trailer_ok  = (b == regs.trailer_byte);
                tally_outcome(r.checksum_ok && r.trailer_ok);
                frames++;
                if (r.checksum_ok && r.trailer_ok) good_frames++;
                queue_result(r);
                phase = PH_HUNT;
                hunt_count = '0;
            end else if (b == regs.header_byte) begin
                hunt_count = '0;
                sum_acc = '0;
                phase = PH_FIRST;
            end else begin
                phase = PH_HUNT;
                if (hunt_count >= regs.hunt_limit) begin
                    hunt_count = '0;
                    tally_outcome(1'b0);
                    r.hunt_timeout = 1'b1;
                    timeouts++;
                    queue_result(r);
                end else begin
                    hunt_count = hunt_count + 5'd1;
                end
            end
        endfunction

        task report(string msg);
            $display("%0t ns: MISMATCH %s", $time, msg);
            errors++;
        endtask

        task compare(string name, int unsigned got, int unsigned want);
            if (got != want) report($sformatf("%s: got %0h, expected %0h", name, got, want));
        endtask

        task check_word(logic [OUT_TDATA_W-1:0] d, logic u);
            t_result want;
            if (results_due.size() == 0) begin
                report($sformatf("result word %h, tuser %b, arrived with none due", d, u));
                return;
            end
            want = results_due.pop_front();
            compare("left_x", 32'(d[7:0]), 32'(want.left_x));
            compare("left_y", 32'(d[15:8]), 32'(want.left_y));
            compare("right_x", 32'(d[23:16]), 32'(want.right_x));
            compare("right_y", 32'(d[31:24]), 32'(want.right_y));
            compare("buttons", 32'(d[47:32]), 32'(want.buttons));
            compare("checksum_ok", 32'(d[48]), 32'(want.checksum_ok));
            compare("trailer_ok", 32'(d[49]), 32'(want.trailer_ok));
            compare("link_lost", 32'(d[50]), 32'(want.link_lost));
            compare("hunt_timeout", 32'(u), 32'(want.hunt_timeout));
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    frame_scoreboard sb = new;
    bit              steady = 1'b0;
    int              stall_left = 0;
    int              cycles = 0;
    int              sent = 0;
    int              settings_used = 1;

    gamepad_frame_receiver_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycles, sb.results_due.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // A result is registered after its byte is taken, so checking before
    // noting the new byte keeps the order of expectations.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tuser);
        if (i_rst_n && s_axis_tvalid && s_axis_tready) sb.accept_byte(s_axis_tdata);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n || steady) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    function automatic logic [7:0] sum_of(logic [47:0] data);
        logic [7:0] s;
        s = '0;
        for (int i = 0; i < 6; i++) s = s + data[8*i +: 8];
        return s;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_frame(input logic [47:0] data, input logic [7:0] sum_byte,
                              input logic [7:0] end_byte);
        send_byte(sb.regs.header_byte);
        for (int i = 0; i < 6; i++) send_byte(data[8*i +: 8]);
        send_byte(sum_byte);
        send_byte(end_byte);
    endtask

    // Stick and button bytes lean towards the nominal range and the
    // configured header and trailer values.
    task automatic send_random_frame();
        logic [47:0] data;
        logic [7:0]  sum_byte;
        logic [7:0]  end_byte;
        int          r;
        for (int i = 0; i < 6; i++) begin
            r = $urandom_range(0, 9);
            if (r < 4) data[8*i +: 8] = 8'($urandom_range(0, 100));
            else if (r < 8) data[8*i +: 8] = rand_byte();
            else if (r == 8) data[8*i +: 8] = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
            else data[8*i +: 8] = $urandom_range(0, 1) ? sb.regs.header_byte
                                                        : sb.regs.trailer_byte;
        end
        sum_byte = ($urandom_range(0, 99) < 85) ? sum_of(data) : rand_byte();
        end_byte = ($urandom_range(0, 99) < 85) ? sb.regs.trailer_byte : rand_byte();
        send_frame(data, sum_byte, end_byte);
    endtask

    task automatic quiesce(input int settle);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.results_due.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        sb.write_reg(idx, v);
    endtask

    task automatic load_regs(input logic [7:0] hdr, input logic [7:0] trl,
                             input logic [7:0] hunt_raw, input logic [7:0] fail_raw);
        write_reg(CFG_HEADER, hdr);
        write_reg(CFG_TRAILER, trl);
        write_reg(CFG_HUNT, hunt_raw);
        write_reg(CFG_FAIL, fail_raw);
        i_cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    initial begin
        logic [47:0] data;
        logic [7:0]  hdr;
        logic [7:0]  trl;
        logic [4:0]  hunt;
        logic [2:0]  fail;
        int          start;
        int          r;
        bit          paused;

        paused = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A good frame with the header value inside it, then a bad checksum.
        data = 48'h00_FF_64_00_FF_EB;
        send_frame(data, sum_of(data), TRAILER_RST);
        data = 48'hFF_00_FF_64_00_00;
        send_frame(data, sum_of(data) + 8'd1, TRAILER_RST);
        quiesce(4);
        // Zero hunt and failure limits: each stray byte times out at once.
        load_regs(HEADER_RST, TRAILER_RST, 8'hE0, 8'hF8);
        send_byte(8'h00);
        send_byte(8'hFF);

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            quiesce(4);
            case (p)
                0: begin hdr = HEADER_RST; trl = TRAILER_RST; hunt = HUNT_RST; fail = FAIL_RST; end
                1: begin hdr = 8'h00; trl = 8'hFF; hunt = 5'd31; fail = 3'd7; end
                2: begin hdr = 8'hFF; trl = 8'h00; hunt = 5'd0;  fail = 3'd0; end
                3: begin hdr = 8'h55; trl = 8'hAA; hunt = 5'd3;  fail = 3'd1; end
                default: begin
                    hdr  = rand_byte();
                    trl  = rand_byte();
                    hunt = 5'($urandom_range(0, 31));
                    fail = 3'($urandom_range(0, 7));
                end
            endcase
            load_regs(hdr, trl, {3'($urandom_range(0, 7)), hunt},
                      {5'($urandom_range(0, 31)), fail});
            steady = (p == 3);
            start = sent;
            while (sent - start < PHASE_BYTES) begin
                if ((p == 0 && !paused && sent - start >= PHASE_BYTES / 2) ||
                    $urandom_range(0, 49) == 0) begin
                    quiesce(0);
                    paused = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    send_random_frame();
                end else if (r < 85) begin
                    repeat ($urandom_range(1, int'(sb.regs.hunt_limit) + 3))
                        send_byte(rand_byte());
                end else begin
                    send_byte(sb.regs.header_byte);
                    repeat (8) send_byte(rand_byte());
                end
            end
            steady = 1'b0;
        end

        quiesce(8);
        if (sb.results_due.size() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.results_due.size()));
        $display("Sent %0d bytes under %0d register settings in %0d cycles.",
                 sb.bytes_in, settings_used, cycles);
        $display("Saw %0d frames (%0d good), %0d hunt timeouts, %0d with link lost.",
                 sb.frames, sb.good_frames, sb.timeouts, sb.lost_results);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
